// ----- design/bsmt_pkg.sv -----
// shared constants, types and codes for the block signature match table
package bsmt_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int STRONG_BITS = 64;

    localparam int NUM_CELLS = (MAX_BLOCKS < 8) ? MAX_BLOCKS : 8;
    localparam int ROWS      = (MAX_BLOCKS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWC_W    = $clog2(ROWS + 1);
    localparam int LANE_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [31:0]            wsum;
        logic [STRONG_BITS-1:0] ssum;
        logic [31:0]            ident;
    } entry_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        entry_t           entry;
    } wr_t;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [ROW_W-1:0]       row;
        logic [CNT_W-1:0]       left;
        logic [31:0]            wsum;
        logic [STRONG_BITS-1:0] ssum;
        logic                   found;
        logic [31:0]            id;
    } token_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_id;
    } rsp_t;

endpackage

// ----- design/bsmt_req_if.sv -----
// request channel: action and signature fields
interface bsmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] weak_sum;
    logic [63:0] strong_sum;
    logic [31:0] block_id;

    modport source (output valid, action, weak_sum, strong_sum, block_id, input ready);
    modport sink (input valid, action, weak_sum, strong_sum, block_id, output ready);
endinterface

// ----- design/bsmt_rsp_if.sv -----
// response channel: status and matching block id
interface bsmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] match_id;

    modport source (output valid, status, match_id, input ready);
    modport sink (input valid, status, match_id, output ready);
endinterface

// ----- design/bsmt_cell.sv -----
// search cell: one bank of stored signatures and one stage of the search chain
module bsmt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  bsmt_pkg::wr_t    wr,
    input  bsmt_pkg::token_t tok_in,
    output bsmt_pkg::token_t tok_out
);
    import bsmt_pkg::*;

    entry_t mem [ROWS];
    entry_t rd_reg;
    token_t stage_reg;
    logic   hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr.row] <= wr.entry;
        end
        rd_reg <= mem[tok_in.row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= tok_in;
        end
    end

    assign hit = stage_reg.valid && (stage_reg.left != '0) && !stage_reg.found
                 && (rd_reg.wsum == stage_reg.wsum) && (rd_reg.ssum == stage_reg.ssum);

    always_comb
    begin
        tok_out = stage_reg;
        if (stage_reg.left != '0)
        begin
            tok_out.left = stage_reg.left - CNT_W'(1);
        end
        if (hit)
        begin
            tok_out.found = 1'b1;
            tok_out.id    = rd_reg.ident;
        end
    end

endmodule

// ----- design/block_signature_match_table_core.sv -----
// top level: request decode, load placement, search sequencer and response buffer
// clear, load and unused actions: the response is pushed into the response buffer when the request is taken
// query: one row of 8 banks entering the cell chain per cycle
// query on an empty table: a miss response is pushed when the request is taken; one request is worked on at a time
// reset empties the table and the response buffer; stored signatures are not cleared
module block_signature_match_table_core (
    input  logic       clk,
    input  logic       rst_n,
    bsmt_req_if.sink   req,
    bsmt_rsp_if.source rsp
);
    import bsmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LANE_W-1:0]      lane_reg, lane_next;
    logic [ROWC_W-1:0]      row_reg, row_next;
    logic [CNT_W-1:0]       issue_left_reg, issue_left_next;
    logic [ROW_W-1:0]       issue_row_reg, issue_row_next;
    logic [31:0]            key_weak_reg, key_weak_next;
    logic [STRONG_BITS-1:0] key_strong_reg, key_strong_next;
    logic                   best_found_reg, best_found_next;
    logic [31:0]            best_id_reg, best_id_next;
    rsp_t                   out_reg, out_next, hold_reg, hold_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   hold_valid_reg, hold_valid_next;

    logic                   accept;
    logic                   pop;
    logic                   push;
    rsp_t                   push_data;
    logic                   issue_last;
    logic                   found_now;
    logic [31:0]            id_now;
    logic [NUM_CELLS-1:0]   wr_en;
    wr_t                    wr;
    token_t                 tok [NUM_CELLS+1];
    token_t                 tok_exit;

    assign req.ready = (state_reg == S_IDLE) && !hold_valid_reg;
    assign accept    = req.valid && req.ready;
    assign pop       = out_valid_reg && rsp.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_reg.status;
    assign rsp.match_id = out_reg.match_id;

    assign issue_last = (issue_left_reg <= CNT_W'(NUM_CELLS));

    assign wr.row          = row_reg[ROW_W-1:0];
    assign wr.entry.wsum   = req.weak_sum;
    assign wr.entry.ssum   = req.strong_sum[STRONG_BITS-1:0];
    assign wr.entry.ident  = req.block_id;

    always_comb
    begin
        tok[0]        = '0;
        tok[0].valid  = (state_reg == S_ISSUE);
        tok[0].last   = issue_last;
        tok[0].row    = issue_row_reg;
        tok[0].left   = issue_left_reg;
        tok[0].wsum   = key_weak_reg;
        tok[0].ssum   = key_strong_reg;
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        bsmt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en[g]),
            .wr      (wr),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tok_exit  = tok[NUM_CELLS];
    assign found_now = best_found_reg || tok_exit.found;
    assign id_now    = best_found_reg ? best_id_reg : tok_exit.id;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lane_next       = lane_reg;
        row_next        = row_reg;
        issue_left_next = issue_left_reg;
        issue_row_next  = issue_row_reg;
        key_weak_next   = key_weak_reg;
        key_strong_next = key_strong_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        wr_en           = '0;
        push            = 1'b0;
        push_data       = '0;

        if (tok_exit.valid && tok_exit.found && !best_found_reg)
        begin
            best_found_next = 1'b1;
            best_id_next    = tok_exit.id;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    push             = 1'b1;
                    push_data.status = ST_DONE;
                    unique case (req.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            lane_next  = '0;
                            row_next   = '0;
                        end
                        ACT_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAX_BLOCKS))
                            begin
                                push_data.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en[lane_reg] = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                if (lane_reg == LANE_W'(NUM_CELLS - 1))
                                begin
                                    lane_next = '0;
                                    row_next  = row_reg + ROWC_W'(1);
                                end
                                else
                                begin
                                    lane_next = lane_reg + LANE_W'(1);
                                end
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                push_data.status = ST_MISS;
                            end
                            else
                            begin
                                push            = 1'b0;
                                key_weak_next   = req.weak_sum;
                                key_strong_next = req.strong_sum[STRONG_BITS-1:0];
                                issue_left_next = count_reg;
                                issue_row_next  = '0;
                                best_found_next = 1'b0;
                                state_next      = S_ISSUE;
                            end
                        end
                        default:
                        begin
                            push_data.status = ST_DONE;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                issue_row_next = issue_row_reg + ROW_W'(1);
                if (issue_last)
                begin
                    issue_left_next = '0;
                    state_next      = S_DRAIN;
                end
                else
                begin
                    issue_left_next = issue_left_reg - CNT_W'(NUM_CELLS);
                end
            end
            S_DRAIN:
            begin
                if (tok_exit.valid && tok_exit.last)
                begin
                    push               = 1'b1;
                    push_data.status   = found_now ? ST_MATCH : ST_MISS;
                    push_data.match_id = found_now ? id_now : 32'd0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (!out_valid_reg || pop)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = hold_reg;
                hold_valid_next = push;
                hold_next       = push_data;
            end
            else
            begin
                out_valid_next  = push;
                out_next        = push_data;
                hold_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            hold_valid_next = 1'b1;
            hold_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            lane_reg       <= '0;
            row_reg        <= '0;
            issue_left_reg <= '0;
            issue_row_reg  <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lane_reg       <= lane_next;
            row_reg        <= row_next;
            issue_left_reg <= issue_left_next;
            issue_row_reg  <= issue_row_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_weak_reg   <= key_weak_next;
        key_strong_reg <= key_strong_next;
        best_id_reg    <= best_id_next;
        out_reg        <= out_next;
        hold_reg       <= hold_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("entry count above capacity");

    a_hold_order: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("second response slot filled while first is empty");

    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_exit.valid && tok_exit.last) |-> (state_reg == S_DRAIN))
        else $error("final search token left the chain outside drain");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == ACT_QUERY) && (count_reg != '0)) |=> (state_reg == S_ISSUE))
        else $error("query on a loaded table did not start a search");

    a_no_push_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && hold_valid_reg) |-> pop)
        else $error("response pushed with no free slot");

endmodule

// ----- tb/tb_block_signature_match_table_core.sv -----
// testbench for the block signature match table: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_block_signature_match_table_core;
    import bsmt_pkg::*;

    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [31:0] TAG_ALIAS   = 32'h5a5a_5a5a;
    localparam int          SEARCH_LAT  = ROWS + 10;
    localparam int          HOLD_CYCLES = 400;

    class sig_scoreboard;
        logic [31:0]            tab_weak   [MAX_BLOCKS];
        logic [STRONG_BITS-1:0] tab_strong [MAX_BLOCKS];
        logic [31:0]            tab_id     [MAX_BLOCKS];
        int unsigned            fill;
        rsp_t                   pending [$];
        int unsigned            n_load, n_drop, n_query, n_hit, n_other, n_checked;

        function void note_request(logic [1:0] act, logic [31:0] w_sum, logic [63:0] s_sum,
                                   logic [31:0] id);
            rsp_t                   r;
            logic [STRONG_BITS-1:0] s;
            s = s_sum[STRONG_BITS-1:0];
            r.status   = ST_DONE;
            r.match_id = '0;
            case (act)
                ACT_CLEAR:
                begin
                    fill = 0;
                    n_other++;
                end
                ACT_LOAD:
                begin
                    n_load++;
                    if (fill >= MAX_BLOCKS)
                    begin
                        r.status = ST_FULL;
                        n_drop++;
                    end
                    else
                    begin
                        tab_weak[fill]   = w_sum;
                        tab_strong[fill] = s;
                        tab_id[fill]     = id;
                        fill++;
                    end
                end
                ACT_QUERY:
                begin
                    n_query++;
                    r.status = ST_MISS;
                    for (int i = 0; i < fill && r.status == ST_MISS; i++)
                    begin
                        if (tab_weak[i] == w_sum && tab_strong[i] == s)
                        begin
                            r.status   = ST_MATCH;
                            r.match_id = tab_id[i];
                        end
                    end
                    if (r.status == ST_MATCH)
                        n_hit++;
                end
                default:
                    n_other++;
            endcase
            pending.push_back(r);
        endfunction

        function string check_response(logic [1:0] status, logic [31:0] match_id);
            rsp_t  want;
            string why;
            if (pending.size() == 0)
                return $sformatf("response status %0d id %h with nothing pending",
                                 status, match_id);
            want = pending.pop_front();
            n_checked++;
            why = "";
            if (status !== want.status)
                why = {why, $sformatf(" status %0d expected %0d", status, want.status)};
            if (match_id !== want.match_id)
                why = {why, $sformatf(" match_id %h expected %h", match_id, want.match_id)};
            if (why != "")
                why = $sformatf("response %0d:%s", n_checked, why);
            return why;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bsmt_req_if req();
    bsmt_rsp_if rsp();

    block_signature_match_table_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sig_scoreboard sb;
    int            send_idle_pct;
    int            stall_pct;
    int            mismatches;
    bit            holding;
    event          hold_go;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @hold_go;
            @(posedge clk);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    always @(negedge clk)
        rsp.ready <= !holding && ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : rsp_monitor
        string why;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            why = sb.check_response(rsp.status, rsp.match_id);
            if (why != "")
                report_mismatch(why);
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [31:0] w_sum,
                                input logic [63:0] s_sum, input logic [31:0] id);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid      = 1'b1;
        req.action     = act;
        req.weak_sum   = w_sum;
        req.strong_sum = s_sum;
        req.block_id   = id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(act, w_sum, s_sum, id);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SEARCH_LAT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_request();
        int unsigned r;
        int unsigned k;
        logic [31:0] w;
        logic [63:0] s;
        logic [15:0] h;
        r = $urandom_range(0, 99);
        k = 0;
        w = $urandom;
        s = {$urandom, $urandom};
        if (sb.fill > 0)
            k = $urandom_range(0, sb.fill - 1);
        if (r < 3)
            send_request(ACT_CLEAR, w, s, $urandom);
        else if (r < 6)
            send_request(ACT_UNUSED, w, s, $urandom);
        else if (r < ((sb.fill < 48) ? 45 : 15))
        begin
            // reuse a stored weak sum, sometimes the whole signature
            if (sb.fill > 0 && r % 4 == 0)
            begin
                w = sb.tab_weak[k];
                if (r % 8 == 0)
                    s = 64'(sb.tab_strong[k]);
            end
            send_request(ACT_LOAD, w, s, $urandom);
        end
        else
        begin
            r = $urandom_range(0, 99);
            h = 16'($urandom_range(1, 65535));
            if (sb.fill > 0 && r < 60)
            begin
                w = sb.tab_weak[k];
                s = 64'(sb.tab_strong[k]);
            end
            else if (sb.fill > 0 && r < 75)
            begin
                w = sb.tab_weak[k];
                s = 64'(sb.tab_strong[k]) ^ (64'd1 << $urandom_range(0, 63));
            end
            else if (sb.fill > 0 && r < 88)
            begin
                // same folded tag, different weak sum
                w = sb.tab_weak[k] ^ {h, h};
                s = 64'(sb.tab_strong[k]);
            end
            send_request(ACT_QUERY, w, s, $urandom);
        end
    endtask

    initial
    begin
        sb             = new;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.action     = ACT_CLEAR;
        req.weak_sum   = '0;
        req.strong_sum = '0;
        req.block_id   = '0;
        rsp.ready      = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        mismatches     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(ACT_QUERY, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'd0);
        send_request(ACT_UNUSED, '1, '1, '1);
        send_request(ACT_LOAD, '0, '0, '0);
        send_request(ACT_LOAD, '1, '1, '1);
        send_request(ACT_QUERY, '0, '0, '1);
        send_request(ACT_QUERY, '1, '1, '0);
        send_request(ACT_LOAD, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'd5);
        send_request(ACT_LOAD, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'd6);
        send_request(ACT_QUERY, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'd0);
        send_request(ACT_LOAD, 32'h1234_5678, 64'hfedc_ba98_7654_3210, 32'd7);
        send_request(ACT_QUERY, 32'h1234_5678, 64'hfedc_ba98_7654_3210, 32'd0);
        send_request(ACT_QUERY, 32'h1234_5678 ^ TAG_ALIAS, 64'h0123_4567_89ab_cdef, 32'd0);
        send_request(ACT_LOAD, 32'h1234_5678 ^ TAG_ALIAS, 64'h0123_4567_89ab_cdef, 32'd8);
        send_request(ACT_QUERY, 32'h1234_5678 ^ TAG_ALIAS, 64'h0123_4567_89ab_cdef, 32'd0);
        send_request(ACT_QUERY, 32'h1234_5678, 64'h0123_4567_89ab_cdee, 32'd0);
        send_request(ACT_CLEAR, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 32'd9);
        send_request(ACT_QUERY, '0, '0, '0);
        send_request(ACT_LOAD, 32'haaaa_5555, 64'h5555_aaaa_5555_aaaa, 32'h5555_aaaa);
        send_request(ACT_QUERY, 32'haaaa_5555, 64'h5555_aaaa_5555_aaaa, 32'haaaa_5555);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            repeat (100) random_request();
            wait_drained();
        end

        // receiver holds off while requests keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_go;
        repeat (24) random_request();
        wait_drained();

        // fill the table to capacity, then overflow it
        send_request(ACT_CLEAR, '0, '0, '0);
        for (int i = 0; i < MAX_BLOCKS; i++)
            send_request(ACT_LOAD, $urandom, {$urandom, $urandom}, $urandom);
        send_request(ACT_LOAD, $urandom, {$urandom, $urandom}, $urandom);
        send_request(ACT_LOAD, sb.tab_weak[0], 64'(sb.tab_strong[0]), $urandom);
        send_request(ACT_QUERY, sb.tab_weak[MAX_BLOCKS-1], 64'(sb.tab_strong[MAX_BLOCKS-1]),
                     '0);
        send_request(ACT_QUERY, sb.tab_weak[0], 64'(sb.tab_strong[0]), '0);
        send_request(ACT_QUERY, sb.tab_weak[MAX_BLOCKS/2], 64'(sb.tab_strong[MAX_BLOCKS/2]),
                     '0);
        send_request(ACT_QUERY, $urandom, {$urandom, $urandom}, '0);
        send_request(ACT_CLEAR, '0, '0, '0);
        send_request(ACT_QUERY, sb.tab_weak[0], 64'(sb.tab_strong[0]), '0);
        wait_drained();

        $display("covered %0d loads (%0d dropped on a full table), %0d queries (%0d hits)",
                 sb.n_load, sb.n_drop, sb.n_query, sb.n_hit);
        $display("plus %0d clear/unused requests; %0d responses checked, %0d mismatches",
                 sb.n_other, sb.n_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
